/* src/adsr_pkg.sv */
// Package: widths, codes, reset values and the pole arithmetic of the ADSR envelope.
`default_nettype none
package adsr_pkg;

  localparam int FRAC_BITS = 24;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int FB_W      = FRAC_BITS;
  localparam int BIAS_W    = FRAC_BITS + 2;
  localparam int SUM_W     = BIAS_W + 2;
  localparam int PROD_W    = LEVEL_W + FB_W;
  localparam int PHASE_W   = 3;
  localparam int OP_W      = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = BIAS_W;

  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

  localparam logic [PHASE_W-1:0] PH_OFF     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_RETRIG  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_FB   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_BIAS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FB    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_BIAS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FB  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_BIAS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd7;

  localparam int MODE_LEGATO = 0;
  localparam int MODE_GATE   = 1;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(longint'(1) << FRAC_BITS);
  localparam logic [SUM_W-1:0]   SUM_ONE   = SUM_W'(longint'(1) << FRAC_BITS);

  localparam logic signed [BIAS_W-1:0] RETRIG_BIAS =
    BIAS_W'(-(((longint'(1) << FRAC_BITS) * 1376 + 50000) / 100000));
  localparam logic [FB_W-1:0] RETRIG_FB =
    FB_W'(((longint'(1) << FRAC_BITS) * 9862 + 5000) / 10000);

  localparam logic [FB_W-1:0]          RST_ATTACK_FB    = FB_W'(16560000);
  localparam logic signed [BIAS_W-1:0] RST_ATTACK_BIAS  = BIAS_W'(278000);
  localparam logic [FB_W-1:0]          RST_DECAY_FB     = FB_W'(16700000);
  localparam logic signed [BIAS_W-1:0] RST_DECAY_BIAS   = BIAS_W'(50000);
  localparam logic [FB_W-1:0]          RST_RELEASE_FB   = FB_W'(16720000);
  localparam logic signed [BIAS_W-1:0] RST_RELEASE_BIAS = BIAS_W'(-500);
  localparam logic [LEVEL_W-1:0]       RST_SUSTAIN      = LEVEL_W'(11861000);
  localparam logic [MODE_W-1:0]        RST_MODE         = MODE_W'(0);

  typedef struct packed {
    logic [FB_W-1:0]          attack_feedback;
    logic signed [BIAS_W-1:0] attack_bias;
    logic [FB_W-1:0]          decay_feedback;
    logic signed [BIAS_W-1:0] decay_bias;
    logic [FB_W-1:0]          release_feedback;
    logic signed [BIAS_W-1:0] release_bias;
    logic [LEVEL_W-1:0]       sustain_level;
    logic [MODE_W-1:0]        mode_flags;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] last_level;
    logic               last_gate;
  } state_t;

  // level = bias + (last * fb) >> FRAC_BITS, saturated into [0, ONE]
  function automatic logic [LEVEL_W-1:0] pole(
    input logic [LEVEL_W-1:0]       last,
    input logic signed [BIAS_W-1:0] bias,
    input logic [FB_W-1:0]          fb
  );
    logic [PROD_W-1:0]        prod;
    logic [LEVEL_W-1:0]       prod_sh;
    logic signed [SUM_W-1:0]  sum;
    logic [LEVEL_W-1:0]       res;
    prod    = PROD_W'(last) * PROD_W'(fb);
    prod_sh = prod[PROD_W-1:FRAC_BITS];
    sum     = $signed({{(SUM_W-LEVEL_W){1'b0}}, prod_sh}) +
              $signed({{(SUM_W-BIAS_W){bias[BIAS_W-1]}}, bias});
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (sum > $signed(SUM_ONE)) begin
      res = LEVEL_ONE;
    end else begin
      res = sum[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* src/adsr_step.sv */
// Envelope step: next phase, level and gate for one item from the current state.
`default_nettype none
module adsr_step (
  input  wire adsr_pkg::state_t             st,
  input  wire adsr_pkg::cfg_t               cfg,
  input  wire [adsr_pkg::OP_W-1:0]          op,
  input  wire                               gate,
  output adsr_pkg::state_t                  st_next,
  output logic [adsr_pkg::LEVEL_W-1:0]      level,
  output logic                              active
);

  logic                                gate_mode;
  logic                                legato;
  logic [adsr_pkg::LEVEL_W-1:0]        sus;
  logic [adsr_pkg::FB_W-1:0]           fb;
  logic signed [adsr_pkg::BIAS_W-1:0]  bias;
  logic [adsr_pkg::LEVEL_W-1:0]        p;
  logic [adsr_pkg::LEVEL_W-1:0]        v;

  assign gate_mode = cfg.mode_flags[adsr_pkg::MODE_GATE];
  assign legato    = cfg.mode_flags[adsr_pkg::MODE_LEGATO];
  assign sus = (cfg.sustain_level > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE
                                                         : cfg.sustain_level;

  always_comb begin
    unique case (st.phase) inside
      adsr_pkg::PH_ATTACK: begin
        fb   = cfg.attack_feedback;
        bias = cfg.attack_bias;
      end
      adsr_pkg::PH_DECAY, adsr_pkg::PH_SUSTAIN: begin
        fb   = cfg.decay_feedback;
        bias = cfg.decay_bias;
      end
      adsr_pkg::PH_RELEASE: begin
        fb   = cfg.release_feedback;
        bias = cfg.release_bias;
      end
      default: begin
        fb   = adsr_pkg::RETRIG_FB;
        bias = adsr_pkg::RETRIG_BIAS;
      end
    endcase
  end

  assign p = adsr_pkg::pole(st.last_level, bias, fb);

  always_comb begin
    st_next = st;
    v       = '0;
    unique case (op)
      adsr_pkg::OP_NOTE_ON: begin
        if (!gate_mode) begin
          if (st.phase != adsr_pkg::PH_OFF && !legato) begin
            st_next.phase = adsr_pkg::PH_RETRIG;
          end else if (st.phase == adsr_pkg::PH_OFF ||
                       st.phase == adsr_pkg::PH_RELEASE) begin
            st_next.phase = adsr_pkg::PH_ATTACK;
          end
        end
      end
      adsr_pkg::OP_NOTE_OFF: begin
        if (!gate_mode) begin
          st_next.phase = adsr_pkg::PH_RELEASE;
        end
      end
      adsr_pkg::OP_TICK: begin
        unique case (st.phase)
          adsr_pkg::PH_ATTACK: begin
            v = p;
            if (p >= adsr_pkg::LEVEL_ONE) begin
              v = adsr_pkg::LEVEL_ONE;
              st_next.phase = adsr_pkg::PH_DECAY;
            end
          end
          adsr_pkg::PH_DECAY: begin
            v = p;
            if (p <= sus) begin
              v = sus;
              st_next.phase = adsr_pkg::PH_SUSTAIN;
            end
          end
          adsr_pkg::PH_SUSTAIN: begin
            v = (st.last_level > sus) ? p : sus;
          end
          adsr_pkg::PH_RELEASE: begin
            v = p;
            if (p == '0) begin
              st_next.phase = adsr_pkg::PH_OFF;
            end
          end
          adsr_pkg::PH_RETRIG: begin
            v = p;
            if (p == '0) begin
              st_next.phase = adsr_pkg::PH_ATTACK;
            end
          end
          default: begin
            v = '0;
            st_next.phase = adsr_pkg::PH_OFF;
          end
        endcase
        st_next.last_level = v;
        if (gate_mode) begin
          if (gate && !st.last_gate) begin
            st_next.phase = adsr_pkg::PH_ATTACK;
          end else if (!gate && st.last_gate) begin
            st_next.phase = adsr_pkg::PH_RELEASE;
          end
          st_next.last_gate = gate;
        end
      end
      default: begin
      end
    endcase
  end

  assign level  = v;
  assign active = (st_next.phase != adsr_pkg::PH_OFF);

endmodule
`default_nettype wire

/* src/adsr_envelope_generator.sv */
// Top level: ADSR envelope generator with input stage, envelope state and result register.
//
// Input channel (in_valid / in_stall): operation 0 is a sample tick, 1 note on,
// 2 note off; gate_level is read on ticks in gate mode. Each tick gives one
// result item (level, active) on the output channel (out_valid / out_stall);
// note events and the unused code give none.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): eight registers,
// always ready; write only while the block is idle.
// A tick held in the input register moves to the result register once that is free.
// Throughput: one item per cycle while out_stall is low. The envelope update
// is one multiply-add and clamp between the input register and the result
// register, and the state feeds back to itself in that same cycle.
// Stall: a held result keeps its value; a tick waiting in the input register
// holds in_stall high until the result register frees. Note events pass on.
// Reset: phase off, level zero, gate low, registers at their default values,
// both channels empty.
`default_nettype none
module adsr_envelope_generator (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [adsr_pkg::OP_W-1:0]             operation,
  input  wire                                  gate_level,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [adsr_pkg::LEVEL_W-1:0]         level,
  output logic                                 active,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [adsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [adsr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  adsr_pkg::cfg_t               cfg;
  adsr_pkg::state_t             st;
  adsr_pkg::state_t             st_next;
  logic                         s1_valid;
  logic [adsr_pkg::OP_W-1:0]    s1_op;
  logic                         s1_gate;
  logic                         s1_go;
  logic                         out_free;
  logic                         s1_tick;
  logic [adsr_pkg::LEVEL_W-1:0] level_next;
  logic                         active_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign s1_tick   = (s1_op == adsr_pkg::OP_TICK);
  assign s1_go     = s1_valid && (!s1_tick || out_free);
  assign in_stall  = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_feedback  <= adsr_pkg::RST_ATTACK_FB;
      cfg.attack_bias      <= adsr_pkg::RST_ATTACK_BIAS;
      cfg.decay_feedback   <= adsr_pkg::RST_DECAY_FB;
      cfg.decay_bias       <= adsr_pkg::RST_DECAY_BIAS;
      cfg.release_feedback <= adsr_pkg::RST_RELEASE_FB;
      cfg.release_bias     <= adsr_pkg::RST_RELEASE_BIAS;
      cfg.sustain_level    <= adsr_pkg::RST_SUSTAIN;
      cfg.mode_flags       <= adsr_pkg::RST_MODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adsr_pkg::REG_ATTACK_FB:    cfg.attack_feedback  <= cfg_data[adsr_pkg::FB_W-1:0];
        adsr_pkg::REG_ATTACK_BIAS:  cfg.attack_bias      <= cfg_data;
        adsr_pkg::REG_DECAY_FB:     cfg.decay_feedback   <= cfg_data[adsr_pkg::FB_W-1:0];
        adsr_pkg::REG_DECAY_BIAS:   cfg.decay_bias       <= cfg_data;
        adsr_pkg::REG_RELEASE_FB:   cfg.release_feedback <= cfg_data[adsr_pkg::FB_W-1:0];
        adsr_pkg::REG_RELEASE_BIAS: cfg.release_bias     <= cfg_data;
        adsr_pkg::REG_SUSTAIN:      cfg.sustain_level    <= cfg_data[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::REG_MODE:         cfg.mode_flags       <= cfg_data[adsr_pkg::MODE_W-1:0];
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op   <= operation;
      s1_gate <= gate_level;
    end
  end

  adsr_step u_step (
    .st      (st),
    .cfg     (cfg),
    .op      (s1_op),
    .gate    (s1_gate),
    .st_next (st_next),
    .level   (level_next),
    .active  (active_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= adsr_pkg::PH_OFF;
      st.last_level <= '0;
      st.last_gate  <= 1'b0;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_tick) begin
      level  <= level_next;
      active <= active_next;
    end
  end

  a_off_is_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> level == '0)
    else $error("envelope off with nonzero level");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= adsr_pkg::LEVEL_ONE)
    else $error("level above full scale");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    st.phase <= adsr_pkg::PH_RETRIG)
    else $error("unused phase code reached");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(s1_valid && s1_op == adsr_pkg::OP_TICK))
    else $error("result without a tick");

  a_stall_holds_tick: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_tick && out_valid)
    else $error("input stalled without a blocked tick");

endmodule
`default_nettype wire
